>>> src/gsad_pkg.sv
package gsad_pkg;

    // Widths of the fixed-point datapath: unsigned, 12 integer and 28 fraction bits.
    // The tail scan can push the base value past 6, so 12 integer bits are kept.
    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 28;
    localparam int IW       = 40;
    localparam int SEG_W    = 5;
    localparam int SCAN_W   = WORD_W - 6;
    localparam int DIGIT_W  = 8;
    localparam int DIGITS   = IW / DIGIT_W;
    localparam int CNT_W    = $clog2(DIGITS);
    localparam int CFG_IDX_W = 1;

    localparam logic [63:0] DEC_SCALE = 64'd10000000000;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STD  = 1'b1;

    localparam logic [31:0] STD_RESET = 32'd65536;

    typedef logic [63:0]   t_dec_tab [32];
    typedef logic [IW-1:0] t_fx_tab  [32];

    // Decimal constant (value times 1e10) to internal fixed point, rounded to nearest.
    function automatic logic [IW-1:0] fx(input logic [63:0] dec);
        logic [63:0] q;
        logic [63:0] r;
        q = (dec / DEC_SCALE) << FRAC_W;
        r = dec % DEC_SCALE;
        for (int b = FRAC_W - 1; b >= 0; b--) begin
            r = r * 2;
            if (r >= DEC_SCALE) begin
                r = r - DEC_SCALE;
                q = q | (64'd1 << b);
            end
        end
        if (r * 2 >= DEC_SCALE) begin
            q = q + 64'd1;
        end
        return q[IW-1:0];
    endfunction

    function automatic t_fx_tab fx_tab(input t_dec_tab d);
        t_fx_tab res;
        for (int i = 0; i < 32; i++) begin
            res[i] = fx(d[i]);
        end
        return res;
    endfunction

    localparam t_dec_tab TAB_A_DEC = '{
        64'd0, 64'd391760900, 64'd784124100, 64'd1177700000, 64'd1573107000,
        64'd1970991000, 64'd2372021000, 64'd2776904000, 64'd3186394000,
        64'd3601300000, 64'd4022501000, 64'd4450965000, 64'd4887764000,
        64'd5334097000, 64'd5791322000, 64'd6260990000, 64'd6744898000,
        64'd7245144000, 64'd7764218000, 64'd8305109000, 64'd8871466000,
        64'd9467818000, 64'd10099900000, 64'd10775160000, 64'd11503490000,
        64'd12298590000, 64'd13180110000, 64'd14177970000, 64'd15341210000,
        64'd16759400000, 64'd18627320000, 64'd21538750000};

    // Last entry is padding and never read.
    localparam t_dec_tab TAB_D_DEC = '{
        64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd2636843000, 64'd2425085000,
        64'd2255674000, 64'd2116342000, 64'd1999243000, 64'd1899108000,
        64'd1812252000, 64'd1736014000, 64'd1668419000, 64'd1607967000,
        64'd1553497000, 64'd1504094000, 64'd1459026000, 64'd1417700000,
        64'd1379632000, 64'd1344418000, 64'd1311722000, 64'd1281260000,
        64'd1252791000, 64'd1226109000, 64'd1201036000, 64'd1177417000,
        64'd1155119000, 64'd1134023000, 64'd1114027000, 64'd1095039000, 64'd0};

    localparam t_dec_tab TAB_T_DEC = '{
        64'd7673828, 64'd23068700, 64'd38606180, 64'd54384540, 64'd70507000,
        64'd87083960, 64'd104235700, 64'd122095300, 64'd140812500, 64'd160557900,
        64'd181529000, 64'd203957300, 64'd228117700, 64'd254340700, 64'd283029600,
        64'd314682200, 64'd349923300, 64'd389548300, 64'd434587800, 64'd486403500,
        64'd546833400, 64'd618422200, 64'd704798300, 64'd811319500, 64'd946244400,
        64'd1123001000, 64'd1364980000, 64'd1716886000, 64'd2276241000,
        64'd3304980000, 64'd5847031000, 64'd7673828};

    localparam t_dec_tab TAB_H_DEC = '{
        64'd392061700, 64'd393270500, 64'd395100000, 64'd397570300, 64'd400709300,
        64'd404553300, 64'd409148100, 64'd414550700, 64'd420831100, 64'd428074800,
        64'd436386300, 64'd445893200, 64'd456752300, 64'd469157100, 64'd483348700,
        64'd499629800, 64'd518385900, 64'd540113800, 64'd565465600, 64'd595313000,
        64'd630848900, 64'd673750300, 64'd726454400, 64'd792647100, 64'd878192200,
        64'd993039800, 64'd1155600000, 64'd1404344000, 64'd1836142000,
        64'd2790016000, 64'd7010474000, 64'd392061700};

    localparam t_fx_tab A_FX = fx_tab(TAB_A_DEC);
    localparam t_fx_tab D_FX = fx_tab(TAB_D_DEC);
    localparam t_fx_tab T_FX = fx_tab(TAB_T_DEC);
    localparam t_fx_tab H_FX = fx_tab(TAB_H_DEC);

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_START, OP_SCAN, OP_LD_U, OP_LD_US, OP_TT_U, OP_MUL, OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        MS_CENTER_W, MS_CW, MS_TAIL_W, MS_BOUND, MS_EMIT
    } t_msel;

    typedef struct packed {
        t_op   op;
        t_msel msel;
    } t_cmd;

    typedef struct packed {
        logic seg_zero;
        logic scan_done;
        logic ustar_le_t;
        logic ustar_gt_tt;
        logic ustar_ge_u;
        logic mul_done;
        logic out_free;
    } t_status;

endpackage

>>> src/gsad_mul.sv
module gsad_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gsad_pkg::IW-1:0]     i_a,
    input  logic [gsad_pkg::IW-1:0]     i_b,
    output logic                        o_done,
    output logic [2*gsad_pkg::IW-1:0]   o_product
);

    localparam int IW = gsad_pkg::IW;
    localparam int DW = gsad_pkg::DIGIT_W;

    logic [IW-1:0]              r_a;
    logic [IW-1:0]              r_b;
    logic [IW-1:0]              r_hi;
    logic [IW-1:0]              r_lo;
    logic [gsad_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [IW+DW:0]             n_sum;

    // One 8-bit digit of b per cycle; low product bits shift into r_lo.
    assign n_sum = (IW+DW+1)'(r_hi) + (IW+DW+1)'(r_a * r_b[DW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == gsad_pkg::CNT_W'(gsad_pkg::DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
        end else if (r_busy) begin
            r_hi <= n_sum[IW+DW-1:DW];
            r_lo <= {n_sum[DW-1:0], r_lo[IW-1:DW]};
            r_b  <= r_b >> DW;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

>>> src/gsad_datapath.sv
module gsad_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gsad_pkg::t_cmd                    i_cmd,
    output gsad_pkg::t_status                 o_status,
    input  logic [gsad_pkg::WORD_W-1:0]       i_uniform_word,
    input  logic                              i_cfg_we,
    input  logic [gsad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [31:0]                o_sample
);

    localparam int IW   = gsad_pkg::IW;
    localparam int FW   = gsad_pkg::FRAC_W;
    localparam int SW   = gsad_pkg::SCAN_W;
    localparam int WW   = gsad_pkg::WORD_W;
    localparam logic [WW-1:0] HALF = WW'(1) << (WW - 1);
    localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
    localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

    logic [WW-1:0]            r_x;
    logic                     r_neg;
    logic [4:0]               r_seg;
    logic [SW-1:0]            r_frac;
    logic [IW-1:0]            r_aa;
    logic [IW-1:0]            r_ustar;
    logic [IW-1:0]            r_u;
    logic [IW-1:0]            r_tt;
    logic [IW-1:0]            r_w;
    logic [IW-1:0]            r_mag;
    gsad_pkg::t_msel          r_msel;
    logic signed [31:0]       r_mean;
    logic [31:0]              r_std;
    logic                     r_valid;
    logic signed [31:0]       r_sample;

    logic                     x_neg;
    logic [WW-1:0]            x_fold;
    logic [5:0]               x_seg;
    logic [4:0]               start_seg;
    logic [4:0]               seg_m1;
    logic [SW:0]              frac2;
    logic [IW-1:0]            q;
    logic [IW-1:0]            mul_a;
    logic [IW-1:0]            mul_b;
    logic                     mul_start;
    logic                     mul_done;
    logic [2*IW-1:0]          product;
    logic [IW-1:0]            prod_sh;
    logic signed [41:0]       s_mean;
    logic signed [41:0]       s_mag;
    logic signed [41:0]       s_sum;
    logic signed [31:0]       sat_val;

    assign x_neg     = r_x > HALF;
    assign x_fold    = x_neg ? r_x - HALF : r_x;
    assign x_seg     = x_fold[WW-1:SW];
    assign start_seg = x_seg[5] ? 5'd31 : x_seg[4:0];
    assign seg_m1    = r_seg - 5'd1;
    assign frac2     = {r_frac, 1'b0};
    assign q         = IW'(r_x[WW-1:WW-FW]);

    assign mul_start = (i_cmd.op == gsad_pkg::OP_MUL);

    always_comb begin
        case (i_cmd.msel)
            gsad_pkg::MS_CENTER_W: begin
                mul_a = r_ustar - gsad_pkg::T_FX[seg_m1];
                mul_b = gsad_pkg::H_FX[seg_m1];
            end
            gsad_pkg::MS_CW: begin
                mul_a = r_u;
                mul_b = gsad_pkg::A_FX[r_seg] - r_aa;
            end
            gsad_pkg::MS_TAIL_W: begin
                mul_a = r_u;
                mul_b = gsad_pkg::D_FX[seg_m1];
            end
            gsad_pkg::MS_BOUND: begin
                mul_a = r_w + {r_aa[IW-2:0], 1'b0};
                mul_b = r_w;
            end
            gsad_pkg::MS_EMIT: begin
                mul_a = IW'(r_std);
                mul_b = r_aa + r_w;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gsad_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (product)
    );

    // The bound carries an extra halving.
    assign prod_sh = (r_msel == gsad_pkg::MS_BOUND) ? product[FW+IW:FW+1]
                                                    : product[FW+IW-1:FW];

    assign s_mean = 42'(r_mean);
    assign s_mag  = signed'({2'b00, r_mag});
    assign s_sum  = r_neg ? s_mean - s_mag : s_mean + s_mag;

    always_comb begin
        if (s_sum > SAT_MAX) begin
            sat_val = 32'sh7fff_ffff;
        end else if (s_sum < SAT_MIN) begin
            sat_val = 32'sh8000_0000;
        end else begin
            sat_val = s_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_std   <= gsad_pkg::STD_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == gsad_pkg::CFG_MEAN) begin
                    r_mean <= i_cfg_data;
                end else if (i_cfg_index == gsad_pkg::CFG_STD) begin
                    r_std <= i_cfg_data;
                end
            end
            if (i_cmd.op == gsad_pkg::OP_OUT) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_done) begin
            case (r_msel)
                gsad_pkg::MS_BOUND: r_tt  <= prod_sh;
                gsad_pkg::MS_EMIT:  r_mag <= prod_sh;
                default:            r_w   <= prod_sh;
            endcase
        end
        case (i_cmd.op)
            gsad_pkg::OP_LOAD: r_x <= i_uniform_word;
            gsad_pkg::OP_START: begin
                r_neg  <= x_neg;
                r_frac <= x_fold[SW-1:0];
                if (x_seg != 6'd0) begin
                    r_seg   <= start_seg;
                    r_ustar <= x_seg[5] ? IW'(1) << FW : IW'({x_fold[SW-1:0], 2'b00});
                    r_aa    <= gsad_pkg::A_FX[start_seg - 5'd1];
                end else begin
                    r_seg <= 5'd6;
                    r_aa  <= gsad_pkg::A_FX[31];
                end
            end
            gsad_pkg::OP_SCAN: begin
                r_frac <= frac2[SW-1:0];
                if (frac2[SW] || r_seg == 5'd31) begin
                    r_u <= IW'({frac2[SW-1:0], 2'b00});
                end else begin
                    r_aa  <= r_aa + gsad_pkg::D_FX[seg_m1];
                    r_seg <= r_seg + 5'd1;
                end
            end
            gsad_pkg::OP_LD_U:  r_u     <= q;
            gsad_pkg::OP_LD_US: r_ustar <= q;
            gsad_pkg::OP_TT_U:  r_tt    <= r_u;
            gsad_pkg::OP_MUL:   r_msel  <= i_cmd.msel;
            gsad_pkg::OP_OUT:   r_sample <= sat_val;
            default: ;
        endcase
    end

    assign o_status.seg_zero    = (x_seg == 6'd0);
    assign o_status.scan_done   = frac2[SW] || (r_seg == 5'd31);
    assign o_status.ustar_le_t  = r_ustar <= gsad_pkg::T_FX[seg_m1];
    assign o_status.ustar_gt_tt = r_ustar > r_tt;
    assign o_status.ustar_ge_u  = r_ustar >= r_u;
    assign o_status.mul_done    = mul_done;
    assign o_status.out_free    = !r_valid || !i_out_stall;

    assign o_out_valid = r_valid;
    assign o_sample    = r_sample;

endmodule

>>> src/gsad_ctrl.sv
module gsad_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gsad_pkg::t_status i_status,
    output gsad_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        PH_START = 8'b0000_0001,
        PH_C_W   = 8'b0000_0010,
        PH_C_U   = 8'b0000_0100,
        PH_C_S80 = 8'b0000_1000,
        PH_C_S40 = 8'b0001_0000,
        PH_T_US  = 8'b0010_0000,
        PH_T_U   = 8'b0100_0000,
        PH_T_W   = 8'b1000_0000
    } t_phase;

    typedef enum logic [15:0] {
        S_WAIT    = 16'h0001,
        S_DISP    = 16'h0002,
        S_SCAN    = 16'h0004,
        S_CCHK    = 16'h0008,
        S_CU      = 16'h0010,
        S_CMPT    = 16'h0020,
        S_TAIL    = 16'h0040,
        S_CW      = 16'h0080,
        S_WMUL_E  = 16'h0100,
        S_WMUL_B  = 16'h0200,
        S_EMIT_GO = 16'h0400,
        S_BND_GO  = 16'h0800,
        S_BMUL    = 16'h1000,
        S_BCHK    = 16'h2000,
        S_EMUL    = 16'h4000,
        S_OUT     = 16'h8000
    } t_state;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_phase <= PH_START;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        o_cmd.op   = gsad_pkg::OP_NONE;
        o_cmd.msel = gsad_pkg::MS_CENTER_W;
        case (r_state)
            S_WAIT: begin
                if (i_in_valid) begin
                    o_cmd.op = gsad_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (r_phase)
                    PH_START: begin
                        o_cmd.op = gsad_pkg::OP_START;
                        n_state  = i_status.seg_zero ? S_SCAN : S_CCHK;
                    end
                    PH_C_W: begin
                        o_cmd.op = gsad_pkg::OP_LD_U;
                        n_state  = S_CW;
                    end
                    PH_C_U, PH_T_U: begin
                        o_cmd.op = gsad_pkg::OP_LD_U;
                        n_state  = S_CU;
                    end
                    PH_C_S80, PH_T_US: begin
                        o_cmd.op = gsad_pkg::OP_LD_US;
                        n_state  = S_CMPT;
                    end
                    PH_C_S40: begin
                        o_cmd.op = gsad_pkg::OP_LD_US;
                        n_state  = S_CCHK;
                    end
                    default: begin
                        o_cmd.op = gsad_pkg::OP_LD_U;
                        n_state  = S_TAIL;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.op = gsad_pkg::OP_SCAN;
                if (i_status.scan_done) begin
                    n_state = S_TAIL;
                end
            end
            S_CCHK: begin
                if (i_status.ustar_le_t) begin
                    n_phase = PH_C_W;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.op   = gsad_pkg::OP_MUL;
                    o_cmd.msel = gsad_pkg::MS_CENTER_W;
                    n_state    = S_WMUL_E;
                end
            end
            S_CU: begin
                if (i_status.ustar_ge_u) begin
                    o_cmd.op = gsad_pkg::OP_TT_U;
                    n_phase  = (r_phase == PH_C_U) ? PH_C_S80 : PH_T_US;
                end else begin
                    n_phase  = (r_phase == PH_C_U) ? PH_C_S40 : PH_T_W;
                end
                n_state = S_WAIT;
            end
            S_CMPT: begin
                if (i_status.ustar_gt_tt) begin
                    n_state = S_EMIT_GO;
                end else begin
                    n_phase = (r_phase == PH_C_S80) ? PH_C_U : PH_T_U;
                    n_state = S_WAIT;
                end
            end
            S_TAIL: begin
                o_cmd.op   = gsad_pkg::OP_MUL;
                o_cmd.msel = gsad_pkg::MS_TAIL_W;
                n_state    = S_WMUL_B;
            end
            S_CW: begin
                o_cmd.op   = gsad_pkg::OP_MUL;
                o_cmd.msel = gsad_pkg::MS_CW;
                n_state    = S_WMUL_B;
            end
            S_WMUL_E: begin
                if (i_status.mul_done) begin
                    n_state = S_EMIT_GO;
                end
            end
            S_WMUL_B: begin
                if (i_status.mul_done) begin
                    n_state = S_BND_GO;
                end
            end
            S_EMIT_GO: begin
                o_cmd.op   = gsad_pkg::OP_MUL;
                o_cmd.msel = gsad_pkg::MS_EMIT;
                n_state    = S_EMUL;
            end
            S_BND_GO: begin
                o_cmd.op   = gsad_pkg::OP_MUL;
                o_cmd.msel = gsad_pkg::MS_BOUND;
                n_state    = S_BMUL;
            end
            S_BMUL: begin
                if (i_status.mul_done) begin
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                if (r_phase == PH_C_W) begin
                    if (i_status.ustar_gt_tt) begin
                        n_state = S_EMIT_GO;
                    end else begin
                        n_phase = PH_C_U;
                        n_state = S_WAIT;
                    end
                end else begin
                    n_phase = PH_T_US;
                    n_state = S_WAIT;
                end
            end
            S_EMUL: begin
                if (i_status.mul_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = gsad_pkg::OP_OUT;
                    n_phase  = PH_START;
                    n_state  = S_WAIT;
                end
            end
            default: begin
                n_state = S_WAIT;
                n_phase = PH_START;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_WAIT);

endmodule

>>> src/gaussian_sampler_ahrens_dieter.sv
// Normal sampler after the Ahrens-Dieter FL method with 32 segments, fed by
// uniform random words. Each input item on i_uniform_word (valid/stall) is one
// 32-bit word. The first word of a sample picks sign and segment; rejection
// steps take further words, so a sample consumes a varying number of items.
// Each accepted value y leaves as one item on o_sample: std_dev*y + mean_value
// in signed Q16.16, saturated. Internal arithmetic is unsigned Q12.28.
// Each product runs on the shared 40x8 digit multiplier: one step to start it,
// five digit steps and one to hand back the result. A tail first word runs 1 to
// 26 doubling steps of the scan. o_in_stall is low only while the controller
// waits for a word. The result sits in an output register: while the receiver
// stalls, the next word is still taken, and the block waits only when a second
// result is ready and the first is not gone. Configuration (index 0 mean,
// index 1 standard deviation) is written through i_cfg_we; the user must write
// it only while idle, which the block itself does not enforce. Synchronous
// reset restores mean 0, deviation 1.0 and the start of a fresh sample, and
// drops any result not yet taken.
module gaussian_sampler_ahrens_dieter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [31:0]                    i_uniform_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [31:0]             o_sample,
    input  logic                           i_cfg_we,
    input  logic [gsad_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    // Commands from the controller and flags back from the datapath.
    gsad_pkg::t_cmd    cmd;
    gsad_pkg::t_status status;

    gsad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: sample state, constant tables, shared multiplier, output register.
    gsad_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_uniform_word (i_uniform_word),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_sample       (o_sample)
    );

endmodule
